// ===== src/fly_camera_pose_update_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the camera pose unit
// Shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef FLY_CAMERA_POSE_UPDATE_DEFINES_SVH
`define FLY_CAMERA_POSE_UPDATE_DEFINES_SVH

// Overlapping implication, checked while reset is released.
`define FCPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication: the consequent is checked in the cycle after the antecedent.
`define FCPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpu_pkg
// Types and constants of the first-person camera pose unit.
// ----------------------------------------------------------------------------
package fcpu_pkg;

  // Angles in degrees Q16.16.
  localparam logic signed [27:0] TURN_FULL    = 28'sd23592960;
  localparam logic signed [27:0] TURN_HALF    = 28'sd11796480;
  localparam logic signed [27:0] TURN_QUARTER = 28'sd5898240;
  localparam logic signed [27:0] PITCH_LIMIT  = 28'sd5832704;

  localparam logic [24:0] YAW_RESET = 25'd17694720;
  localparam logic [15:0] FOV_RESET = 16'd11520;
  localparam logic [15:0] FOV_CEIL  = 16'd46080;
  localparam logic signed [17:0] MIN_VIEW = 18'sd256;
  localparam logic signed [17:0] MAX_VIEW = 18'sd11520;

  localparam logic [15:0] SPEED_RESET = 16'd640;
  localparam logic [15:0] SENS_RESET  = 16'd6554;

  localparam logic signed [15:0] UNIT14 = 16'sd16384;

  // CORDIC gain in Q2.30 and iteration count.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ITER_W = $clog2(CORDIC_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_ROT,
    ST_SCROLL,
    ST_CINIT,
    ST_CITER,
    ST_CDONE,
    ST_BMUL,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    CFG_SPEED,
    CFG_SENS,
    CFG_START_X,
    CFG_START_Y,
    CFG_START_Z,
    CFG_START_YAW,
    CFG_START_PITCH,
    CFG_START_FOV
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FN_MOVE   = 2'd0,
    FN_ROTATE = 2'd1,
    FN_SCROLL = 2'd2
  } func_e;

  // Arctangent of 2^-i in degrees Q16.16.
  function automatic logic signed [26:0] atan_deg(input logic [ITER_W-1:0] i);
    logic signed [26:0] r;
    begin
      case (i)
        4'd0:    r = 27'sd2949120;
        4'd1:    r = 27'sd1740967;
        4'd2:    r = 27'sd919879;
        4'd3:    r = 27'sd466945;
        4'd4:    r = 27'sd234379;
        4'd5:    r = 27'sd117304;
        4'd6:    r = 27'sd58666;
        4'd7:    r = 27'sd29335;
        4'd8:    r = 27'sd14668;
        4'd9:    r = 27'sd7334;
        4'd10:   r = 27'sd3667;
        4'd11:   r = 27'sd1833;
        4'd12:   r = 27'sd917;
        4'd13:   r = 27'sd458;
        4'd14:   r = 27'sd229;
        default: r = 27'sd115;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/fly_camera_pose_update.sv =====
// ----------------------------------------------------------------------------
// fly_camera_pose_update
// First-person camera pose unit: move, rotate and zoom events in fixed point.
// ----------------------------------------------------------------------------
// Usage: each event is a transfer on the input channel (in_valid_i/in_stall_o)
// and produces exactly one pose transfer on the output channel
// (out_valid_o/out_stall_i). Registers are written through the configuration
// channel (cfg_valid_i/cfg_ready_o); writing start_yaw or start_pitch also
// recomputes the basis vectors, which keeps the port busy while it does so.
// One event is worked on at a time and the input stalls meanwhile. Rotate
// uses the shared CORDIC unit, which runs 16 iterations for yaw and again
// for pitch, followed by four products on the shared multiplier. The
// multiplier also forms the move step and the three position increments,
// one axis per cycle. The pose leaves through an output register, so a new
// event is accepted while an earlier pose still waits; if the receiver
// stalls, the finished event waits in its last state until the output
// register frees up. Reset loads speed 640, sensitivity 6554, position zero,
// yaw 270 degrees, pitch zero, fov 45 degrees and the matching basis; no
// clearing pass.
// ----------------------------------------------------------------------------
`include "fly_camera_pose_update_defines.svh"

module fly_camera_pose_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [1:0]  horizontal_i,
  input  logic signed [1:0]  vertical_i,
  input  logic [15:0]        delta_time_i,
  input  logic signed [15:0] x_offset_i,
  input  logic signed [15:0] y_offset_i,
  input  logic               constrain_pitch_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic [15:0]        view_angle_o,
  output logic [24:0]        yaw_out_o,
  output logic signed [24:0] pitch_out_o,
  // Configuration channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  fcpu_pkg::state_e state_q, state_d;

  // Live state.
  logic [15:0]        speed_q, sens_q;
  logic signed [31:0] pos_q [3];
  logic [24:0]        yaw_q;
  logic signed [24:0] pitch_q;
  logic [15:0]        fov_q;
  logic signed [15:0] front_q [3];
  logic signed [15:0] up_q [3];
  logic signed [15:0] right_x_q, right_z_q;

  // Latched event fields.
  logic signed [1:0]  hor_q, ver_q;
  logic [15:0]        dt_q;
  logic signed [15:0] xo_q, yo_q;
  logic               clamp_en_q;
  logic               emit_q;

  // Sequencer and shared multiplier.
  logic [2:0]         op_q;
  logic signed [50:0] prod_q;
  logic [31:0]        step_q;

  // CORDIC unit.
  logic signed [33:0] crd_x_q, crd_y_q;
  logic signed [26:0] crd_z_q;
  logic [fcpu_pkg::ITER_W-1:0] iter_q;
  logic               sel_q, flip_q;
  logic signed [15:0] sin_yaw_q, cos_yaw_q, sin_pitch_q, cos_pitch_q;

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] o_pos_q [3];
  logic signed [15:0] o_front_q [3];
  logic signed [15:0] o_up_q [3];
  logic [15:0]        o_fov_q;
  logic [24:0]        o_yaw_q;
  logic signed [24:0] o_pitch_q;

  logic cfg_fire, in_fire, out_load;

  // A configuration write takes priority over an event in the same cycle.
  assign cfg_ready_o = (state_q == fcpu_pkg::ST_IDLE);
  assign in_stall_o  = (state_q != fcpu_pkg::ST_IDLE) || cfg_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == fcpu_pkg::ST_DONE) && emit_q
                       && (!out_valid_q || !out_stall_i);

  // Signed direction with the pattern -2 read as -1, applied to a component.
  function automatic logic signed [17:0] dir_term(input logic signed [1:0] dir,
                                                  input logic signed [15:0] val);
    logic signed [17:0] v;
    begin
      v = {{2{val[15]}}, val};
      if (dir == 2'sd0) begin
        return 18'sd0;
      end else if (dir == 2'sd1) begin
        return v;
      end else begin
        return -v;
      end
    end
  endfunction

  // Round a Q2.30 CORDIC output half up to Q1.14 and clamp to one.
  function automatic logic signed [15:0] cordic_round(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) begin
        return fcpu_pkg::UNIT14;
      end else if (r < -34'sd16384) begin
        return -fcpu_pkg::UNIT14;
      end else begin
        return r[15:0];
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Combinational datapath.
  // ---------------------------------------------------------------------------
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [17:0] dvec [3];
  logic signed [50:0] mv_round, rot_round, b_round;
  logic signed [28:0] mv_add;
  logic signed [31:0] mv_pos;
  logic signed [33:0] mv_sum;
  logic signed [31:0] mv_sat;
  logic signed [25:0] rot_delta;
  logic signed [26:0] yaw_sum, yaw_wrap;
  logic signed [26:0] pitch_sum, pitch_lim;
  logic signed [27:0] pitch_t, pitch_w;
  logic signed [15:0] b_prod14;
  logic signed [26:0] ci_a, ci_z0, ci_z;
  logic               ci_flip;
  logic signed [33:0] cx_sh, cy_sh;
  logic signed [15:0] cd_cos, cd_sin;
  logic signed [17:0] fov_sum, fov_new;
  logic [24:0]        cfg_yaw;
  logic signed [27:0] cfg_pt;
  logic               sg_neg;

  always_comb begin
    dvec[0] = dir_term(ver_q, front_q[0]) + dir_term(hor_q, right_x_q);
    dvec[1] = dir_term(ver_q, front_q[1]);
    dvec[2] = dir_term(ver_q, front_q[2]) + dir_term(hor_q, right_z_q);

    mul_a = 18'sd0;
    mul_b = 33'sd0;
    case (state_q)
      fcpu_pkg::ST_MOVE: begin
        case (op_q)
          3'd0: begin
            mul_a = {2'b00, dt_q};
            mul_b = {17'd0, speed_q};
          end
          3'd2: begin
            mul_a = dvec[0];
            mul_b = {1'b0, step_q};
          end
          3'd3: begin
            mul_a = dvec[1];
            mul_b = {1'b0, step_q};
          end
          3'd4: begin
            mul_a = dvec[2];
            mul_b = {1'b0, step_q};
          end
          default: ;
        endcase
      end
      fcpu_pkg::ST_ROT: begin
        mul_b = {17'd0, sens_q};
        mul_a = (op_q == 3'd0) ? {{2{xo_q[15]}}, xo_q} : {{2{yo_q[15]}}, yo_q};
      end
      fcpu_pkg::ST_BMUL: begin
        case (op_q)
          3'd0: begin
            mul_a = {{2{cos_yaw_q[15]}}, cos_yaw_q};
            mul_b = {{17{cos_pitch_q[15]}}, cos_pitch_q};
          end
          3'd1: begin
            mul_a = {{2{sin_yaw_q[15]}}, sin_yaw_q};
            mul_b = {{17{cos_pitch_q[15]}}, cos_pitch_q};
          end
          3'd2: begin
            mul_a = {{2{cos_yaw_q[15]}}, cos_yaw_q};
            mul_b = {{17{sin_pitch_q[15]}}, sin_pitch_q};
          end
          3'd3: begin
            mul_a = {{2{sin_yaw_q[15]}}, sin_yaw_q};
            mul_b = {{17{sin_pitch_q[15]}}, sin_pitch_q};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    mul_p = 51'(mul_a * mul_b);

    // Move: position += round(d * step >> 22), saturated.
    mv_round = prod_q + 51'sd2097152;
    mv_add   = mv_round[50:22];
    case (op_q)
      3'd3:    mv_pos = pos_q[0];
      3'd4:    mv_pos = pos_q[1];
      default: mv_pos = pos_q[2];
    endcase
    mv_sum = {{2{mv_pos[31]}}, mv_pos} + {{5{mv_add[28]}}, mv_add};
    if (mv_sum > 34'sd2147483647) begin
      mv_sat = 32'sh7fffffff;
    end else if (mv_sum < -34'sd2147483648) begin
      mv_sat = 32'sh80000000;
    end else begin
      mv_sat = mv_sum[31:0];
    end

    // Rotate: delta = round(offset * sensitivity >> 8).
    rot_round = prod_q + 51'sd128;
    rot_delta = rot_round[33:8];
    yaw_sum   = {2'b00, yaw_q} + {rot_delta[25], rot_delta};
    if (yaw_sum < 27'sd0) begin
      yaw_wrap = yaw_sum + 27'(fcpu_pkg::TURN_FULL);
    end else if (yaw_sum >= 27'(fcpu_pkg::TURN_FULL)) begin
      yaw_wrap = yaw_sum - 27'(fcpu_pkg::TURN_FULL);
    end else begin
      yaw_wrap = yaw_sum;
    end
    pitch_sum = {{2{pitch_q[24]}}, pitch_q} + {rot_delta[25], rot_delta};
    pitch_lim = pitch_sum;
    if (clamp_en_q) begin
      if (pitch_sum > 27'(fcpu_pkg::PITCH_LIMIT)) begin
        pitch_lim = 27'(fcpu_pkg::PITCH_LIMIT);
      end else if (pitch_sum < -27'(fcpu_pkg::PITCH_LIMIT)) begin
        pitch_lim = -27'(fcpu_pkg::PITCH_LIMIT);
      end
    end
    pitch_t = {pitch_lim[26], pitch_lim} + fcpu_pkg::TURN_HALF;
    if (pitch_t < 28'sd0) begin
      pitch_w = pitch_t + fcpu_pkg::TURN_FULL - fcpu_pkg::TURN_HALF;
    end else if (pitch_t >= fcpu_pkg::TURN_FULL) begin
      pitch_w = pitch_t - fcpu_pkg::TURN_FULL - fcpu_pkg::TURN_HALF;
    end else begin
      pitch_w = pitch_t - fcpu_pkg::TURN_HALF;
    end

    // Basis products in Q1.14.
    b_round  = prod_q + 51'sd8192;
    b_prod14 = b_round[29:14];
    sg_neg   = cos_pitch_q[15];

    // CORDIC start: reduce to [-180,180) and fold into [-90,90].
    ci_a  = sel_q ? {{2{pitch_q[24]}}, pitch_q} : {2'b00, yaw_q};
    ci_z0 = (!sel_q && (ci_a >= 27'(fcpu_pkg::TURN_HALF)))
            ? ci_a - 27'(fcpu_pkg::TURN_FULL) : ci_a;
    ci_flip = 1'b0;
    ci_z    = ci_z0;
    if (ci_z0 > 27'(fcpu_pkg::TURN_QUARTER)) begin
      ci_z    = ci_z0 - 27'(fcpu_pkg::TURN_HALF);
      ci_flip = 1'b1;
    end else if (ci_z0 < -27'(fcpu_pkg::TURN_QUARTER)) begin
      ci_z    = ci_z0 + 27'(fcpu_pkg::TURN_HALF);
      ci_flip = 1'b1;
    end

    cx_sh = crd_x_q >>> iter_q;
    cy_sh = crd_y_q >>> iter_q;

    cd_cos = cordic_round(crd_x_q);
    cd_sin = cordic_round(crd_y_q);
    if (flip_q) begin
      cd_cos = -cd_cos;
      cd_sin = -cd_sin;
    end

    // Scroll: add and clamp the field of view.
    fov_sum = {2'b00, fov_q} + {{2{yo_q[15]}}, yo_q};
    if (fov_sum > fcpu_pkg::MAX_VIEW) begin
      fov_new = fcpu_pkg::MAX_VIEW;
    end else if (fov_sum < fcpu_pkg::MIN_VIEW) begin
      fov_new = fcpu_pkg::MIN_VIEW;
    end else begin
      fov_new = fov_sum;
    end

    // Configuration values for yaw and pitch.
    cfg_yaw = (cfg_data_i[24:0] >= 25'(fcpu_pkg::TURN_FULL))
              ? cfg_data_i[24:0] - 25'(fcpu_pkg::TURN_FULL) : cfg_data_i[24:0];
    cfg_pt  = {{3{cfg_data_i[24]}}, cfg_data_i[24:0]} + fcpu_pkg::TURN_HALF;
    if (cfg_pt < 28'sd0) begin
      cfg_pt = cfg_pt + fcpu_pkg::TURN_FULL;
    end else if (cfg_pt >= fcpu_pkg::TURN_FULL) begin
      cfg_pt = cfg_pt - fcpu_pkg::TURN_FULL;
    end
    cfg_pt = cfg_pt - fcpu_pkg::TURN_HALF;
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcpu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcpu_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          if ((cfg_index_i == fcpu_pkg::CFG_START_YAW) ||
              (cfg_index_i == fcpu_pkg::CFG_START_PITCH)) begin
            state_d = fcpu_pkg::ST_CINIT;
          end
        end else if (in_fire) begin
          unique case (func_i)
            fcpu_pkg::FN_MOVE:   state_d = fcpu_pkg::ST_MOVE;
            fcpu_pkg::FN_ROTATE: state_d = fcpu_pkg::ST_ROT;
            fcpu_pkg::FN_SCROLL: state_d = fcpu_pkg::ST_SCROLL;
            default:             state_d = fcpu_pkg::ST_DONE;
          endcase
        end
      end
      fcpu_pkg::ST_MOVE:   if (op_q == 3'd5) state_d = fcpu_pkg::ST_DONE;
      fcpu_pkg::ST_ROT:    if (op_q == 3'd2) state_d = fcpu_pkg::ST_CINIT;
      fcpu_pkg::ST_SCROLL: state_d = fcpu_pkg::ST_DONE;
      fcpu_pkg::ST_CINIT:  state_d = fcpu_pkg::ST_CITER;
      fcpu_pkg::ST_CITER: begin
        if (iter_q == fcpu_pkg::ITER_W'(fcpu_pkg::CORDIC_STEPS - 1)) begin
          state_d = fcpu_pkg::ST_CDONE;
        end
      end
      fcpu_pkg::ST_CDONE:  state_d = sel_q ? fcpu_pkg::ST_BMUL : fcpu_pkg::ST_CINIT;
      fcpu_pkg::ST_BMUL:   if (op_q == 3'd4) state_d = fcpu_pkg::ST_DONE;
      fcpu_pkg::ST_DONE: begin
        if (!emit_q || !out_valid_q || !out_stall_i) begin
          state_d = fcpu_pkg::ST_IDLE;
        end
      end
      default: state_d = fcpu_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pose state and configuration.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= fcpu_pkg::SPEED_RESET;
      sens_q      <= fcpu_pkg::SENS_RESET;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      pos_q[2]    <= '0;
      yaw_q       <= fcpu_pkg::YAW_RESET;
      pitch_q     <= '0;
      fov_q       <= fcpu_pkg::FOV_RESET;
      front_q[0]  <= '0;
      front_q[1]  <= '0;
      front_q[2]  <= -fcpu_pkg::UNIT14;
      up_q[0]     <= '0;
      up_q[1]     <= fcpu_pkg::UNIT14;
      up_q[2]     <= '0;
      right_x_q   <= fcpu_pkg::UNIT14;
      right_z_q   <= '0;
      emit_q      <= 1'b0;
      op_q        <= '0;
      iter_q      <= '0;
      sel_q       <= 1'b0;
      flip_q      <= 1'b0;
    end else begin
      case (state_q)
        fcpu_pkg::ST_IDLE: begin
          op_q  <= '0;
          sel_q <= 1'b0;
          if (cfg_fire) begin
            emit_q <= 1'b0;
            unique case (cfg_index_i)
              fcpu_pkg::CFG_SPEED:       speed_q  <= cfg_data_i[15:0];
              fcpu_pkg::CFG_SENS:        sens_q   <= cfg_data_i[15:0];
              fcpu_pkg::CFG_START_X:     pos_q[0] <= cfg_data_i;
              fcpu_pkg::CFG_START_Y:     pos_q[1] <= cfg_data_i;
              fcpu_pkg::CFG_START_Z:     pos_q[2] <= cfg_data_i;
              fcpu_pkg::CFG_START_YAW:   yaw_q    <= cfg_yaw;
              fcpu_pkg::CFG_START_PITCH: pitch_q  <= cfg_pt[24:0];
              fcpu_pkg::CFG_START_FOV: begin
                fov_q <= (cfg_data_i[15:0] > fcpu_pkg::FOV_CEIL)
                         ? fcpu_pkg::FOV_CEIL : cfg_data_i[15:0];
              end
              default: ;
            endcase
          end else if (in_fire) begin
            emit_q <= 1'b1;
          end
        end
        fcpu_pkg::ST_MOVE: begin
          op_q <= op_q + 3'd1;
          case (op_q)
            3'd3:    pos_q[0] <= mv_sat;
            3'd4:    pos_q[1] <= mv_sat;
            3'd5:    pos_q[2] <= mv_sat;
            default: ;
          endcase
        end
        fcpu_pkg::ST_ROT: begin
          op_q <= op_q + 3'd1;
          if (op_q == 3'd1) begin
            yaw_q <= yaw_wrap[24:0];
          end else if (op_q == 3'd2) begin
            pitch_q <= pitch_w[24:0];
          end
        end
        fcpu_pkg::ST_SCROLL: fov_q <= fov_new[15:0];
        fcpu_pkg::ST_CINIT: begin
          crd_x_q <= fcpu_pkg::CORDIC_GAIN;
          crd_y_q <= '0;
          crd_z_q <= ci_z;
          flip_q  <= ci_flip;
          iter_q  <= '0;
        end
        fcpu_pkg::ST_CITER: begin
          iter_q <= iter_q + 1'b1;
          if (!crd_z_q[26]) begin
            crd_x_q <= crd_x_q - cy_sh;
            crd_y_q <= crd_y_q + cx_sh;
            crd_z_q <= crd_z_q - fcpu_pkg::atan_deg(iter_q);
          end else begin
            crd_x_q <= crd_x_q + cy_sh;
            crd_y_q <= crd_y_q - cx_sh;
            crd_z_q <= crd_z_q + fcpu_pkg::atan_deg(iter_q);
          end
        end
        fcpu_pkg::ST_CDONE: begin
          op_q  <= '0;
          sel_q <= 1'b1;
          if (sel_q) begin
            sin_pitch_q <= cd_sin;
            cos_pitch_q <= cd_cos;
          end else begin
            sin_yaw_q <= cd_sin;
            cos_yaw_q <= cd_cos;
          end
        end
        fcpu_pkg::ST_BMUL: begin
          op_q <= op_q + 3'd1;
          case (op_q)
            3'd1: front_q[0] <= b_prod14;
            3'd2: front_q[2] <= b_prod14;
            3'd3: up_q[0]    <= sg_neg ? b_prod14 : -b_prod14;
            3'd4: begin
              up_q[2]    <= sg_neg ? b_prod14 : -b_prod14;
              front_q[1] <= sin_pitch_q;
              right_x_q  <= sg_neg ? sin_yaw_q : -sin_yaw_q;
              right_z_q  <= sg_neg ? -cos_yaw_q : cos_yaw_q;
              up_q[1]    <= sg_neg ? -cos_pitch_q : cos_pitch_q;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Event fields, multiplier product and move step: payload only.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_fire) begin
      hor_q      <= horizontal_i;
      ver_q      <= vertical_i;
      dt_q       <= delta_time_i;
      xo_q       <= x_offset_i;
      yo_q       <= y_offset_i;
      clamp_en_q <= constrain_pitch_i;
    end
    if ((state_q == fcpu_pkg::ST_MOVE) && (op_q == 3'd1)) begin
      step_q <= prod_q[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_pos_q   <= pos_q;
      o_front_q <= front_q;
      o_up_q    <= up_q;
      o_fov_q   <= fov_q;
      o_yaw_q   <= yaw_q;
      o_pitch_q <= pitch_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_x_o      = o_pos_q[0];
  assign pos_y_o      = o_pos_q[1];
  assign pos_z_o      = o_pos_q[2];
  assign front_x_o    = o_front_q[0];
  assign front_y_o    = o_front_q[1];
  assign front_z_o    = o_front_q[2];
  assign up_x_o       = o_up_q[0];
  assign up_y_o       = o_up_q[1];
  assign up_z_o       = o_up_q[2];
  assign view_angle_o = o_fov_q;
  assign yaw_out_o    = o_yaw_q;
  assign pitch_out_o  = o_pitch_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `FCPU_ASSERT_NEXT(a_busy_after_event, clk_i, rst_ni, in_fire, !cfg_ready_o,
                    "event transfer did not make the unit busy")
  `FCPU_ASSERT_IMPL(a_load_from_done, clk_i, rst_ni, $rose(out_valid_q),
                    $past(state_q == fcpu_pkg::ST_DONE), "pose loaded outside final state")
  `FCPU_ASSERT_IMPL(a_front_y_unit, clk_i, rst_ni, 1'b1,
                    (front_q[1] <= 16'sd16384) && (front_q[1] >= -16'sd16384),
                    "front y component beyond unit length")

endmodule
